### rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("allocator assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("allocator assertion failed");

`endif

### rtl/p2fl_pkg.sv
// Types, constants and codes of the power-of-two free-list allocator.
`default_nettype none

package p2fl_pkg;

   // Field widths
   localparam int ADDR_W    = 32;
   localparam int SIZE_W    = 16;
   localparam int STAT_W    = 2;
   localparam int LIMIT_W   = 7;
   localparam int CSR_IDX_W = 1;

   // Heap geometry (byte and page counts are powers of two)
   localparam int WORD_BYTES      = 4;
   localparam int PAGE_BYTES      = 4096;
   localparam int HEAP_PAGES      = 64;
   localparam int MAX_BUCKETS     = 10;
   localparam int NUM_BUCKETS_DEF = 10;

   localparam int WORDS_PER_PAGE = PAGE_BYTES / WORD_BYTES;
   localparam int LINK_DEPTH     = HEAP_PAGES * WORDS_PER_PAGE;
   localparam int IDX_W          = $clog2(LINK_DEPTH);
   localparam int LINK_W         = IDX_W + 1;
   localparam int K_W            = $clog2(WORDS_PER_PAGE);
   localparam int PAGE_W         = $clog2(HEAP_PAGES);
   localparam int WB_SH          = $clog2(WORD_BYTES);
   localparam int PAGE_SH        = $clog2(PAGE_BYTES);
   localparam int CLS_W          = $clog2(MAX_BUCKETS + 1);

   // Request codes
   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   // Response status codes
   localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STAT_W-1:0] STAT_TOO_LARGE = 2'd1;
   localparam logic [STAT_W-1:0] STAT_NO_MEMORY = 2'd2;
   localparam logic [STAT_W-1:0] STAT_BAD_FREE  = 2'd3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_HEAP_BASE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEAP_LIMIT = 1'b1;

   // Shared adder request
   typedef struct packed {
      logic              sub;
      logic [ADDR_W-1:0] opa;
      logic [ADDR_W-1:0] opb;
   } alu_req_type;

   // Size class decode result
   typedef struct packed {
      logic [CLS_W-1:0] cls;
      logic             bad_free;
      logic             too_large;
   } cls_info_type;

endpackage

`default_nettype wire

### rtl/p2fl_alu.sv
// Shared 32-bit add/subtract unit used by the decode and fill steps of the sequencer.
`default_nettype none

module p2fl_alu (
   input  p2fl_pkg::alu_req_type      req,
   output logic [p2fl_pkg::ADDR_W-1:0] sum
);
   import p2fl_pkg::*;

   always_comb begin
      if (req.sub) begin
         sum = req.opa - req.opb;
      end else begin
         sum = req.opa + req.opb;
      end
   end

endmodule

`default_nettype wire

### rtl/p2fl_class_dec.sv
// Size class decoder: smallest class whose block holds the requested size.
`default_nettype none

module p2fl_class_dec #(
   parameter int NUM_BUCKETS = p2fl_pkg::NUM_BUCKETS_DEF
) (
   input  logic [p2fl_pkg::SIZE_W-1:0] size_bytes,
   output p2fl_pkg::cls_info_type      info
);
   import p2fl_pkg::*;

   always_comb begin
      logic big;
      big            = 1'b0;
      info.cls       = CLS_W'(NUM_BUCKETS);
      info.bad_free  = 1'b1;
      // walk downward so the smallest fitting class wins
      for (int c = NUM_BUCKETS - 1; c >= 0; c--) begin
         if (ADDR_W'(size_bytes) <= ADDR_W'(WORD_BYTES << c)) begin
            info.cls      = CLS_W'(c);
            info.bad_free = 1'b0;
            big           = (WORD_BYTES << c) > PAGE_BYTES;
         end
      end
      info.too_large = info.bad_free | big;
   end

endmodule

`default_nettype wire

### rtl/power_of_two_free_list_allocator_core.sv
// Top level: sequencer, bucket heads, link memory and page bump counter.
//
// channel   ports                                        handshake
// request   req_func, req_size_bytes, req_block_addr     start & !busy
// response  rsp_result_addr, rsp_status, rsp_new_page,  rsp_valid, one cycle
//           rsp_page_addr
// config    csr_index, csr_wdata                         csr_we
//
// Free: answered from the decode state. Allocate from a non-empty class: decode, then pop.
// Allocate with page refill: decode, fill (one link memory write per carved block),
// decode again, then pop. Errors answer from the decode state.
// The response strobe is high in the first cycle after the last busy cycle; a new
// request may be taken in that same cycle. No clearing pass after reset: the link
// memory is only read at entries written earlier. The receiver cannot stall responses.
`default_nettype none

module power_of_two_free_list_allocator_core #(
   parameter int NUM_BUCKETS = p2fl_pkg::NUM_BUCKETS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_func,
   input  logic [p2fl_pkg::SIZE_W-1:0]    req_size_bytes,
   input  logic [p2fl_pkg::ADDR_W-1:0]    req_block_addr,
   output logic                           rsp_valid,
   output logic [p2fl_pkg::ADDR_W-1:0]    rsp_result_addr,
   output logic [p2fl_pkg::STAT_W-1:0]    rsp_status,
   output logic                           rsp_new_page,
   output logic [p2fl_pkg::ADDR_W-1:0]    rsp_page_addr,
   input  logic                           csr_we,
   input  logic [p2fl_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [p2fl_pkg::ADDR_W-1:0]    csr_wdata
);
   import p2fl_pkg::*;

   localparam int BKT_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_DECODE = 2'd1;
   localparam logic [1:0] ST_FILL   = 2'd2;
   localparam logic [1:0] ST_POP    = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic [ADDR_W-1:0]  heap_base_ff;
   logic [LIMIT_W-1:0] heap_limit_ff;
   logic [LIMIT_W-1:0] pages_used_ff, pages_used_in;

   logic               func_ff;
   logic [BKT_W-1:0]   cls_ff;
   logic               bad_free_ff;
   logic               too_large_ff;
   logic [ADDR_W-1:0]  blk_addr_ff;

   logic [K_W-1:0]     k_ff, k_in;
   logic [LINK_W-1:0]  prev_ff, prev_in;
   logic               new_page_ff, new_page_in;
   logic [ADDR_W-1:0]  page_addr_ff, page_addr_in;
   logic [ADDR_W-1:0]  res_ff, res_in;

   logic               head_vld_ff [NUM_BUCKETS];
   logic [IDX_W-1:0]   head_idx_ff [NUM_BUCKETS];
   logic               head_we;
   logic [LINK_W-1:0]  head_wdata;
   logic [LINK_W-1:0]  head_rd;

   logic [LINK_W-1:0]  link_mem [LINK_DEPTH];
   logic               link_we, link_re;
   logic [IDX_W-1:0]   link_waddr, link_raddr;
   logic [LINK_W-1:0]  link_wdata;
   logic [LINK_W-1:0]  rd_data_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]  rsp_result_ff, rsp_result_in;
   logic [STAT_W-1:0]  rsp_status_ff, rsp_status_in;
   logic               rsp_new_page_ff, rsp_new_page_in;
   logic [ADDR_W-1:0]  rsp_page_addr_ff, rsp_page_addr_in;

   alu_req_type        alu_req;
   logic [ADDR_W-1:0]  alu_sum;
   cls_info_type       cls_info;

   logic               accept;
   logic [IDX_W-1:0]   fill_addr;
   logic [K_W-1:0]     stride;
   logic [LIMIT_W-1:0] lim;
   logic               page_avail;
   logic [IDX_W-1:0]   free_idx;

   p2fl_alu u_alu (
      .req (alu_req),
      .sum (alu_sum)
   );

   p2fl_class_dec #(
      .NUM_BUCKETS (NUM_BUCKETS)
   ) u_class_dec (
      .size_bytes (req_size_bytes),
      .info       (cls_info)
   );

   assign accept     = start & ~busy;
   assign busy       = (state_ff != ST_IDLE);
   assign head_rd    = {head_vld_ff[cls_ff], head_idx_ff[cls_ff]};
   assign fill_addr  = {pages_used_ff[PAGE_W-1:0], k_ff};
   assign stride     = K_W'(1) << cls_ff;
   assign lim        = (heap_limit_ff > LIMIT_W'(HEAP_PAGES)) ? LIMIT_W'(HEAP_PAGES)
                                                              : heap_limit_ff;
   assign page_avail = ({1'b0, pages_used_ff} + (LIMIT_W + 1)'(1)) < {1'b0, lim};
   assign free_idx   = alu_sum[WB_SH +: IDX_W];

   // Sequencer
   always_comb begin
      state_in         = state_ff;
      pages_used_in    = pages_used_ff;
      k_in             = k_ff;
      prev_in          = prev_ff;
      new_page_in      = new_page_ff;
      page_addr_in     = page_addr_ff;
      res_in           = res_ff;
      head_we          = 1'b0;
      head_wdata       = prev_ff;
      link_we          = 1'b0;
      link_waddr       = fill_addr;
      link_wdata       = prev_ff;
      link_re          = 1'b0;
      link_raddr       = head_rd[IDX_W-1:0];
      rsp_valid_in     = 1'b0;
      rsp_result_in    = rsp_result_ff;
      rsp_status_in    = rsp_status_ff;
      rsp_new_page_in  = rsp_new_page_ff;
      rsp_page_addr_in = rsp_page_addr_ff;
      alu_req.sub      = 1'b0;
      alu_req.opa      = heap_base_ff;
      alu_req.opb      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in     = ST_DECODE;
               new_page_in  = 1'b0;
               page_addr_in = '0;
            end
         end

         ST_DECODE: begin
            if (func_ff == FUNC_FREE) begin
               rsp_valid_in    = 1'b1;
               rsp_result_in   = '0;
               rsp_new_page_in = 1'b0;
               rsp_page_addr_in = '0;
               state_in        = ST_IDLE;
               if (bad_free_ff) begin
                  rsp_status_in = STAT_BAD_FREE;
               end else begin
                  alu_req.sub   = 1'b1;
                  alu_req.opa   = blk_addr_ff;
                  alu_req.opb   = heap_base_ff;
                  link_we       = 1'b1;
                  link_waddr    = free_idx;
                  link_wdata    = head_rd;
                  head_we       = 1'b1;
                  head_wdata    = {1'b1, free_idx};
                  rsp_status_in = STAT_OK;
               end
            end else if (too_large_ff) begin
               rsp_valid_in     = 1'b1;
               rsp_result_in    = '0;
               rsp_status_in    = STAT_TOO_LARGE;
               rsp_new_page_in  = 1'b0;
               rsp_page_addr_in = '0;
               state_in         = ST_IDLE;
            end else if (head_rd[LINK_W-1]) begin
               link_re     = 1'b1;
               alu_req.opb = ADDR_W'(head_rd[IDX_W-1:0]) << WB_SH;
               res_in      = alu_sum;
               state_in    = ST_POP;
            end else if (page_avail) begin
               alu_req.opb  = ADDR_W'(pages_used_ff) << PAGE_SH;
               page_addr_in = alu_sum;
               new_page_in  = 1'b1;
               k_in         = '0;
               prev_in      = '0;
               state_in     = ST_FILL;
            end else begin
               rsp_valid_in     = 1'b1;
               rsp_result_in    = '0;
               rsp_status_in    = STAT_NO_MEMORY;
               rsp_new_page_in  = 1'b0;
               rsp_page_addr_in = '0;
               state_in         = ST_IDLE;
            end
         end

         ST_FILL: begin
            // carve one block per cycle, ascending; each links to the one below
            link_we     = 1'b1;
            link_waddr  = fill_addr;
            link_wdata  = prev_ff;
            prev_in     = {1'b1, fill_addr};
            alu_req.opa = ADDR_W'(k_ff);
            alu_req.opb = ADDR_W'(stride);
            k_in        = alu_sum[K_W-1:0];
            if (alu_sum[K_W]) begin
               head_we       = 1'b1;
               head_wdata    = {1'b1, fill_addr};
               pages_used_in = pages_used_ff + LIMIT_W'(1);
               state_in      = ST_DECODE;
            end
         end

         ST_POP: begin
            head_we          = 1'b1;
            head_wdata       = rd_data_ff;
            rsp_valid_in     = 1'b1;
            rsp_result_in    = res_ff;
            rsp_status_in    = STAT_OK;
            rsp_new_page_in  = new_page_ff;
            rsp_page_addr_in = page_addr_ff;
            state_in         = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pages_used_ff <= '0;
         heap_base_ff  <= '0;
         heap_limit_ff <= LIMIT_W'(HEAP_PAGES);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pages_used_ff <= pages_used_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_HEAP_BASE:  heap_base_ff  <= csr_wdata;
               CSR_HEAP_LIMIT: heap_limit_ff <= csr_wdata[LIMIT_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_BUCKETS; i++) begin
            head_vld_ff[i] <= 1'b0;
         end
      end else if (head_we) begin
         head_vld_ff[cls_ff] <= head_wdata[LINK_W-1];
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff      <= req_func;
         cls_ff       <= cls_info.cls[BKT_W-1:0];
         bad_free_ff  <= cls_info.bad_free;
         too_large_ff <= cls_info.too_large;
         blk_addr_ff  <= req_block_addr;
      end
      if (head_we) begin
         head_idx_ff[cls_ff] <= head_wdata[IDX_W-1:0];
      end
      k_ff             <= k_in;
      prev_ff          <= prev_in;
      new_page_ff      <= new_page_in;
      page_addr_ff     <= page_addr_in;
      res_ff           <= res_in;
      rsp_result_ff    <= rsp_result_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_new_page_ff  <= rsp_new_page_in;
      rsp_page_addr_ff <= rsp_page_addr_in;
   end

   // Link memory: one write and one registered read port
   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      if (link_re) begin
         rd_data_ff <= link_mem[link_raddr];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_addr = rsp_result_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_new_page    = rsp_new_page_ff;
   assign rsp_page_addr   = rsp_page_addr_ff;

endmodule

`default_nettype wire

### rtl/p2fl_checker.sv
// Port-level checker for the allocator, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module p2fl_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic                        rsp_valid,
   input logic [p2fl_pkg::ADDR_W-1:0] rsp_result_addr,
   input logic [p2fl_pkg::STAT_W-1:0] rsp_status,
   input logic                        rsp_new_page,
   input logic [p2fl_pkg::ADDR_W-1:0] rsp_page_addr
);
   import p2fl_pkg::*;

   // a transaction is always answered out of a busy cycle
   `ASSERT_IMPL(a_rsp_after_busy, clock, reset, rsp_valid, $past(busy))
   `ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `ASSERT_IMPL(a_err_zero_addr, clock, reset, rsp_valid && (rsp_status != STAT_OK), rsp_result_addr == '0)
   `ASSERT_IMPL(a_page_zero, clock, reset, rsp_valid && !rsp_new_page, rsp_page_addr == '0)
   // a refill always ends in a successful pop
   `ASSERT_IMPL(a_refill_ok, clock, reset, rsp_valid && rsp_new_page, rsp_status == STAT_OK)

endmodule

bind power_of_two_free_list_allocator_core p2fl_checker u_p2fl_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_result_addr (rsp_result_addr),
   .rsp_status      (rsp_status),
   .rsp_new_page    (rsp_new_page),
   .rsp_page_addr   (rsp_page_addr)
);

`default_nettype wire

### tb/tb.sv
// Self-checking testbench for the power-of-two free-list allocator core.
`timescale 1ns / 1ps

module tb;
   import p2fl_pkg::*;

   localparam int RANDOM_PHASES   = 6;
   localparam int ITEMS_PER_PHASE = 188;
   localparam int BURST_PHASE     = 3;
   localparam int SETTLE_CYCLES   = 8;
   localparam int WATCHDOG_LIMIT  = 5000;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [STAT_W-1:0] status;
      logic              new_page;
      logic [ADDR_W-1:0] page_addr;
   } alloc_rsp_type;

   typedef enum logic {ROW_REQ, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type          kind;
      logic                  func;
      logic [SIZE_W-1:0]     size;
      logic [ADDR_W-1:0]     addr;
      logic [CSR_IDX_W-1:0]  csr_sel;
      bit                    typed;
      alloc_rsp_type         rsp;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic                  req_func;
   logic [SIZE_W-1:0]     req_size_bytes;
   logic [ADDR_W-1:0]     req_block_addr;
   logic                  rsp_valid;
   logic [ADDR_W-1:0]     rsp_result_addr;
   logic [STAT_W-1:0]     rsp_status;
   logic                  rsp_new_page;
   logic [ADDR_W-1:0]     rsp_page_addr;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [ADDR_W-1:0]     csr_wdata;

   power_of_two_free_list_allocator_core dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_func        (req_func),
      .req_size_bytes  (req_size_bytes),
      .req_block_addr  (req_block_addr),
      .rsp_valid       (rsp_valid),
      .rsp_result_addr (rsp_result_addr),
      .rsp_status      (rsp_status),
      .rsp_new_page    (rsp_new_page),
      .rsp_page_addr   (rsp_page_addr),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Allocator state as the testbench sees it
   logic [ADDR_W-1:0]  heap_base_r;
   logic [LIMIT_W-1:0] heap_pages_r;
   logic [LINK_W-1:0]  free_head [NUM_BUCKETS_DEF];
   logic [LINK_W-1:0]  next_link [LINK_DEPTH];
   int                 pages_taken;

   alloc_rsp_type      pending_rsp [$];
   logic [ADDR_W-1:0]  live_addr [$];
   int                 live_cls [$];
   bit                 typed_valid;
   alloc_rsp_type      typed_rsp;

   int n_errors;
   int n_accepted;
   int n_checked;
   int status_seen [4];
   int quiet_cycles;

   function automatic int size_class(logic [SIZE_W-1:0] size);
      for (int c = 0; c < NUM_BUCKETS_DEF; c++) begin
         if (32'(size) <= (WORD_BYTES << c)) return c;
      end
      return NUM_BUCKETS_DEF;
   endfunction

   function automatic logic [SIZE_W-1:0] size_in_class(int c);
      int lo;
      int hi;
      hi = WORD_BYTES << c;
      lo = (c == 0) ? 0 : (WORD_BYTES << (c - 1)) + 1;
      return SIZE_W'($urandom_range(hi, lo));
   endfunction

   // Carve the next page into blocks of class c, lowest address pushed first.
   function automatic void carve_page(int c);
      logic [LINK_W-1:0] prev;
      logic [IDX_W-1:0]  idx;
      int                first;
      prev  = '0;
      first = pages_taken * WORDS_PER_PAGE;
      for (int k = 0; k < WORDS_PER_PAGE; k += (1 << c)) begin
         idx = IDX_W'(first + k);
         next_link[idx] = prev;
         prev = {1'b1, idx};
      end
      free_head[c] = prev;
      pages_taken++;
   endfunction

   function automatic alloc_rsp_type predict_alloc_rsp(logic func, logic [SIZE_W-1:0] size,
                                                       logic [ADDR_W-1:0] addr);
      alloc_rsp_type     r;
      int                c;
      int                lim;
      logic [ADDR_W-1:0] diff;
      logic [IDX_W-1:0]  idx;
      r = '0;
      c = size_class(size);
      if (func == FUNC_FREE) begin
         if (c >= NUM_BUCKETS_DEF) begin
            r.status = STAT_BAD_FREE;
         end else begin
            diff = addr - heap_base_r;
            idx = diff[WB_SH +: IDX_W];
            next_link[idx] = free_head[c];
            free_head[c] = {1'b1, idx};
         end
      end else if (c >= NUM_BUCKETS_DEF || (WORD_BYTES << c) > PAGE_BYTES) begin
         r.status = STAT_TOO_LARGE;
      end else begin
         if (!free_head[c][IDX_W]) begin
            lim = (int'(heap_pages_r) > HEAP_PAGES) ? HEAP_PAGES : int'(heap_pages_r);
            if (pages_taken + 1 < lim) begin
               r.new_page  = 1'b1;
               r.page_addr = heap_base_r + (ADDR_W'(pages_taken) << PAGE_SH);
               carve_page(c);
            end else begin
               r.status = STAT_NO_MEMORY;
            end
         end
         if (r.status == STAT_OK) begin
            idx = free_head[c][IDX_W-1:0];
            free_head[c] = next_link[idx];
            r.addr = heap_base_r + (ADDR_W'(idx) << WB_SH);
         end
      end
      return r;
   endfunction

   task automatic flag_field(string fname, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
      n_errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, fname, want, got);
   endtask

   always @(posedge clock) begin : rsp_monitor
      alloc_rsp_type want;
      alloc_rsp_type got;
      if (!reset) begin
         if (rsp_valid) begin
            got = '{rsp_result_addr, rsp_status, rsp_new_page, rsp_page_addr};
            status_seen[got.status]++;
            n_checked++;
            if (pending_rsp.size() == 0) begin
               n_errors++;
               $display("%0t: response with nothing expected, expected none, got %h",
                        $time, got);
            end else begin
               want = pending_rsp.pop_front();
               if (got.addr !== want.addr) flag_field("result_addr", want.addr, got.addr);
               if (got.status !== want.status)
                  flag_field("status", ADDR_W'(want.status), ADDR_W'(got.status));
               if (got.new_page !== want.new_page)
                  flag_field("new_page", ADDR_W'(want.new_page), ADDR_W'(got.new_page));
               if (got.page_addr !== want.page_addr)
                  flag_field("page_addr", want.page_addr, got.page_addr);
            end
         end
         if (start && !busy) begin
            want = predict_alloc_rsp(req_func, req_size_bytes, req_block_addr);
            if (req_func == FUNC_ALLOC && want.status == STAT_OK) begin
               live_addr.push_back(want.addr);
               live_cls.push_back(size_class(req_size_bytes));
            end
            if (typed_valid) begin
               want = typed_rsp;
               typed_valid = 1'b0;
            end
            pending_rsp.push_back(want);
            n_accepted++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles < WATCHDOG_LIMIT) begin
         quiet_cycles <= quiet_cycles + 1;
      end else begin
         $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("tb: failure");
         $finish;
      end
   end

   // Called right after a falling edge; returns at the accepting rising edge.
   task automatic drive_req(logic f, logic [SIZE_W-1:0] sz, logic [ADDR_W-1:0] a,
                            bit typed, alloc_rsp_type rsp);
      req_func       <= f;
      req_size_bytes <= sz;
      req_block_addr <= a;
      start          <= 1'b1;
      typed_valid = typed;
      typed_rsp   = rsp;
      do @(posedge clock); while (busy);
   endtask

   task automatic idle_gap(int n);
      @(negedge clock);
      start <= 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   task automatic drain_rsp();
      @(negedge clock);
      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] sel, logic [ADDR_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= sel;
      csr_wdata <= data;
      if (sel == CSR_HEAP_BASE) heap_base_r = data;
      else                      heap_pages_r = data[LIMIT_W-1:0];
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Mostly frees of live blocks and allocs of legal sizes, with some noise.
   task automatic random_req();
      int                r;
      int                k;
      logic              f;
      logic [SIZE_W-1:0] sz;
      logic [ADDR_W-1:0] a;
      f = FUNC_ALLOC;
      a = $urandom();
      r = $urandom_range(99, 0);
      if (r < 45 && live_addr.size() != 0) begin
         k  = $urandom_range(live_addr.size() - 1, 0);
         f  = FUNC_FREE;
         a  = live_addr[k];
         sz = size_in_class(live_cls[k]);
         live_addr.delete(k);
         live_cls.delete(k);
      end else if (r < 88) begin
         sz = size_in_class($urandom_range(NUM_BUCKETS_DEF - 1, 0));
      end else begin
         f = logic'($urandom_range(1, 0));
         case ($urandom_range(2, 0))
            0: sz = SIZE_W'($urandom_range(65535, (WORD_BYTES << (NUM_BUCKETS_DEF - 1)) + 1));
            1: sz = SIZE_W'($urandom());
            default: begin
               f  = FUNC_FREE;   // stray address
               sz = size_in_class($urandom_range(NUM_BUCKETS_DEF - 1, 0));
            end
         endcase
      end
      drive_req(f, sz, a, 1'b0, '0);
   endtask

   function automatic stim_row_type row_req(logic f, logic [SIZE_W-1:0] sz,
                                            logic [ADDR_W-1:0] a);
      stim_row_type row;
      row = '{ROW_REQ, f, sz, a, CSR_HEAP_BASE, 1'b0, '0};
      return row;
   endfunction

   function automatic stim_row_type row_chk(logic f, logic [SIZE_W-1:0] sz,
                                            logic [ADDR_W-1:0] a, alloc_rsp_type rsp);
      stim_row_type row;
      row = '{ROW_REQ, f, sz, a, CSR_HEAP_BASE, 1'b1, rsp};
      return row;
   endfunction

   function automatic stim_row_type row_csr(logic [CSR_IDX_W-1:0] sel,
                                            logic [ADDR_W-1:0] data);
      stim_row_type row;
      row = '{ROW_CSR, FUNC_ALLOC, '0, data, sel, 1'b0, '0};
      return row;
   endfunction

   stim_row_type      dir_rows [$];
   logic [ADDR_W-1:0] phase_base [RANDOM_PHASES];
   logic [ADDR_W-1:0] phase_limit [RANDOM_PHASES];

   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_func       = FUNC_ALLOC;
      req_size_bytes = '0;
      req_block_addr = '0;
      csr_we         = 1'b0;
      csr_index      = CSR_HEAP_BASE;
      csr_wdata      = '0;
      heap_base_r    = '0;
      heap_pages_r   = LIMIT_W'(HEAP_PAGES);
      pages_taken    = 0;
      typed_valid    = 1'b0;
      typed_rsp      = '0;
      n_errors       = 0;
      n_accepted     = 0;
      n_checked      = 0;
      quiet_cycles   = 0;
      foreach (free_head[c]) free_head[c] = '0;
      foreach (status_seen[s]) status_seen[s] = 0;

      dir_rows = '{
         row_chk(FUNC_ALLOC, 16'd0, 32'd0, alloc_rsp_type'{32'd4092, STAT_OK, 1'b1, 32'd0}),
         row_chk(FUNC_ALLOC, 16'd4, 32'hFFFF_FFFF,
                 alloc_rsp_type'{32'd4088, STAT_OK, 1'b0, 32'd0}),
         row_chk(FUNC_ALLOC, 16'd5, 32'd0,
                 alloc_rsp_type'{32'd8184, STAT_OK, 1'b1, 32'd4096}),
         row_chk(FUNC_ALLOC, 16'd2048, 32'd0,
                 alloc_rsp_type'{32'd10240, STAT_OK, 1'b1, 32'd8192}),
         row_chk(FUNC_ALLOC, 16'd2049, 32'd0,
                 alloc_rsp_type'{32'd0, STAT_TOO_LARGE, 1'b0, 32'd0}),
         row_chk(FUNC_ALLOC, 16'hFFFF, 32'hFFFF_FFFF,
                 alloc_rsp_type'{32'd0, STAT_TOO_LARGE, 1'b0, 32'd0}),
         row_chk(FUNC_FREE, 16'd2049, 32'd4092,
                 alloc_rsp_type'{32'd0, STAT_BAD_FREE, 1'b0, 32'd0}),
         row_chk(FUNC_FREE, 16'hFFFF, 32'hFFFF_FFFF,
                 alloc_rsp_type'{32'd0, STAT_BAD_FREE, 1'b0, 32'd0}),
         row_chk(FUNC_FREE, 16'd4, 32'd4092, alloc_rsp_type'{32'd0, STAT_OK, 1'b0, 32'd0}),
         row_chk(FUNC_ALLOC, 16'd1, 32'd0, alloc_rsp_type'{32'd4092, STAT_OK, 1'b0, 32'd0}),
         row_req(FUNC_FREE, 16'd3, 32'hFFFF_FFFF),     // address wraps into the link store
         row_req(FUNC_ALLOC, 16'd3, 32'd0),
         row_req(FUNC_FREE, 16'd16, 32'h1234_5677),    // misaligned
         row_req(FUNC_ALLOC, 16'd16, 32'd0),
         row_req(FUNC_ALLOC, 16'd8, 32'hFFFF_FFFF),
         row_req(FUNC_FREE, 16'd1024, 32'h8000_0000),  // never allocated
         row_csr(CSR_HEAP_LIMIT, 32'd4),
         row_chk(FUNC_ALLOC, 16'd64, 32'd0,
                 alloc_rsp_type'{32'd0, STAT_NO_MEMORY, 1'b0, 32'd0}),
         row_req(FUNC_ALLOC, 16'd4, 32'd0),
         row_csr(CSR_HEAP_LIMIT, 32'd1),
         row_chk(FUNC_ALLOC, 16'd128, 32'd0,
                 alloc_rsp_type'{32'd0, STAT_NO_MEMORY, 1'b0, 32'd0}),
         row_csr(CSR_HEAP_LIMIT, 32'd64),
         row_csr(CSR_HEAP_BASE, 32'hFFFF_F000),
         row_req(FUNC_ALLOC, 16'd256, 32'd0),          // page address wraps past zero
         row_req(FUNC_FREE, 16'd1024, 32'hFFFF_F000),
         row_req(FUNC_ALLOC, 16'd1024, 32'd0)
      };

      phase_base  = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom(), 32'h8000_0000,
                      $urandom() & ~32'h3, 32'h0000_0000};
      phase_limit = '{32'd64, 32'd63, 32'd1, 32'($urandom_range(HEAP_PAGES, 2)),
                      32'd64, 32'd64};

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_CSR) begin
            drain_rsp();
            write_csr(dir_rows[i].csr_sel, dir_rows[i].addr);
         end else begin
            @(negedge clock);
            drive_req(dir_rows[i].func, dir_rows[i].size, dir_rows[i].addr,
                      dir_rows[i].typed, dir_rows[i].rsp);
         end
      end

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         drain_rsp();
         write_csr(CSR_HEAP_BASE, phase_base[p]);
         write_csr(CSR_HEAP_LIMIT, phase_limit[p]);
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            if (p != BURST_PHASE && $urandom_range(99, 0) < 32)
               idle_gap($urandom_range(6, 1));
            @(negedge clock);
            random_req();
         end
      end

      drain_rsp();
      $display("run covered %0d requests in %0d phases, %0d responses, %0d pages carved",
               n_accepted, RANDOM_PHASES + 1, n_checked, pages_taken);
      $display("statuses: ok %0d, too large %0d, no memory %0d, bad free %0d",
               status_seen[STAT_OK], status_seen[STAT_TOO_LARGE],
               status_seen[STAT_NO_MEMORY], status_seen[STAT_BAD_FREE]);
      if (n_errors == 0) begin
         $display("tb: success");
      end else begin
         $display("%0d mismatches", n_errors);
         $display("tb: failure");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+rtl
rtl/p2fl_pkg.sv
rtl/p2fl_alu.sv
rtl/p2fl_class_dec.sv
rtl/power_of_two_free_list_allocator_core.sv
rtl/p2fl_checker.sv
tb/tb.sv
